// ----- hw/rtl/mtdr_pkg.sv -----
package mtdr_pkg;

    // Build constants
    localparam int TAP_COUNT    = 4;
    localparam int BUFFER_DEPTH = 32768;
    localparam int UNITY_GAIN   = 4096;

    // Fixed register file layout: four delay registers, then four gain registers.
    localparam int MAX_TAPS  = 4;
    localparam int REG_COUNT = 8;

    localparam int SAMPLE_W = 16;
    localparam int DELAY_W  = 15;
    localparam int GAIN_W   = 16;
    localparam int OUT_W    = 32;
    localparam int CFG_W    = 16;

    localparam int ADDR_W     = $clog2(BUFFER_DEPTH);
    localparam int TAP_W      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int IDX_W      = $clog2(REG_COUNT);
    localparam int UNITY_SHIFT = $clog2(UNITY_GAIN);

    // Product of an unsigned gain and a signed sample, and the running sum.
    localparam int PROD_W = GAIN_W + SAMPLE_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;

    localparam logic [IDX_W-1:0] CFG_DELAY_BASE = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_GAIN_BASE  = IDX_W'(MAX_TAPS);

    localparam logic [DELAY_W-1:0] DELAY_RESET [MAX_TAPS] = '{
        DELAY_W'(2400), DELAY_W'(7200), DELAY_W'(12000), DELAY_W'(16800)
    };
    localparam logic [GAIN_W-1:0] GAIN_RESET [MAX_TAPS] = '{
        GAIN_W'(2053), GAIN_W'(1028), GAIN_W'(515), GAIN_W'(258)
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic en;
    } t_mac_ctl;

    typedef struct packed {
        logic                    busy;
        logic signed [OUT_W-1:0] result;
    } t_mac_sts;

endpackage

// ----- hw/rtl/mtdr_store.sv -----
module mtdr_store (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic signed [mtdr_pkg::SAMPLE_W-1:0] i_wr_data,
    input  logic                                 i_rd_en,
    input  logic        [mtdr_pkg::DELAY_W-1:0]  i_rd_delay,
    output logic signed [mtdr_pkg::SAMPLE_W-1:0] o_rd_data
);
    import mtdr_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [BUFFER_DEPTH];
    logic signed [SAMPLE_W-1:0] r_q;
    logic [ADDR_W-1:0] r_wp;
    logic [ADDR_W-1:0] n_wp;
    logic              r_full;
    logic              r_ok;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_written;

    assign n_wp      = r_wp + ADDR_W'(1);
    assign w_rd_addr = r_wp - ADDR_W'(i_rd_delay);

    // Writes fill positions 1, 2, ... in order; position 0 is the last to be
    // written, and from then on every entry holds a real sample.
    assign w_written = r_full || ((w_rd_addr != '0) && (w_rd_addr <= r_wp));

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[n_wp] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q  <= r_mem[w_rd_addr];
            r_ok <= w_written;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (i_wr_en) begin
            r_wp <= n_wp;
            if (n_wp == '0) begin
                r_full <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_ok ? r_q : '0;

    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> (r_wp == $past(n_wp)))
        else $error("write pointer did not advance by one");

    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("store fill flag dropped");

endmodule

// ----- hw/rtl/mtdr_mac.sv -----
module mtdr_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mtdr_pkg::t_mac_ctl                   i_ctl,
    input  logic        [mtdr_pkg::GAIN_W-1:0]   i_gain,
    input  logic signed [mtdr_pkg::SAMPLE_W-1:0] i_sample,
    output mtdr_pkg::t_mac_sts                   o_sts
);
    import mtdr_pkg::*;

    localparam logic signed [PROD_W-1:0] BIAS = PROD_W'(UNITY_GAIN - 1);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_term;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_v1;
    logic                     r_v2;
    logic signed [PROD_W-1:0] w_biased;
    logic                     w_in_range;

    // Division by the unity scale truncates toward zero: negative products
    // are biased up by one less than the scale before the arithmetic shift.
    assign w_biased = r_prod[PROD_W-1] ? (r_prod + BIAS) : r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.en;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'($signed({1'b0, i_gain})) * PROD_W'(i_sample);
        r_term <= w_biased >>> UNITY_SHIFT;
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_term);
        end
    end

    assign w_in_range = (r_acc[ACC_W-1:OUT_W-1] == '0) || (r_acc[ACC_W-1:OUT_W-1] == '1);

    always_comb begin
        o_sts.busy = r_v1 || r_v2;
        if (w_in_range) begin
            o_sts.result = r_acc[OUT_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            o_sts.result = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            o_sts.result = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

endmodule

// ----- hw/rtl/multi_tap_delay_reverb.sv -----
// Mono multi-tap echo. Each accepted beat on the input channel stores one
// signed 16-bit sample in a 32768-entry circular sample memory and yields one
// signed 32-bit beat on the output channel: the sum over the taps of the tap
// gain times the sample stored that many samples back, each term divided by
// the unity gain of 4096 with truncation toward zero, the total saturated to
// 32 bits. A delay of zero returns the sample just written; a gain of zero
// silences its tap. Memory locations never written since reset read as zero,
// so no clearing pass is needed and the block is ready as soon as reset ends.
// Configuration registers 0 to 3 hold the tap delays (15 bits) and 4 to 7 the
// tap gains (16 bits); write them only while the block is idle. A sample
// occupies the block from the accepting clock, which writes the memory,
// through one memory read per tap over the single read port, the drain of
// the read data and the shared multiply, scale and accumulate unit, and the
// load of the output register, which waits until that register is free. The
// input stalls after the accepting clock until the output register is loaded.
// A finished beat waits in the output register, and the next sample is
// already taken while it waits; only the following result waits for the
// output register to empty.
module multi_tap_delay_reverb (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [mtdr_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [mtdr_pkg::OUT_W-1:0]    o_echo_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [mtdr_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic        [mtdr_pkg::CFG_W-1:0]    i_cfg_data
);
    import mtdr_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [DELAY_W-1:0] r_delay [MAX_TAPS];
    logic [GAIN_W-1:0]  r_gain  [MAX_TAPS];

    logic [TAP_W-1:0] r_tap;
    logic [TAP_W-1:0] n_tap;
    logic [TAP_W-1:0] r_tap_d;
    logic             r_rd_v;

    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out;

    logic                       w_accept;
    logic                       w_rd_en;
    logic                       w_load;
    logic signed [SAMPLE_W-1:0] w_rd_data;
    t_mac_ctl                   w_ctl;
    t_mac_sts                   w_sts;
    logic [TAP_W-1:0]           w_cfg_tap;

    // Configuration registers. Register indexes below the gain base select a
    // delay; the rest select a gain. Upper data bits beyond a field are dropped.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_tap   = (i_cfg_index < CFG_GAIN_BASE)
                       ? TAP_W'(i_cfg_index - CFG_DELAY_BASE)
                       : TAP_W'(i_cfg_index - CFG_GAIN_BASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_delay[i] <= DELAY_RESET[i];
                r_gain[i]  <= GAIN_RESET[i];
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index < CFG_GAIN_BASE) begin
                r_delay[w_cfg_tap] <= i_cfg_data[DELAY_W-1:0];
            end else begin
                r_gain[w_cfg_tap] <= i_cfg_data[GAIN_W-1:0];
            end
        end
    end

    // The sample is written on the accepting edge; the tap reads follow, so a
    // zero delay sees the new sample.
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_rd_v  <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tap_d <= r_tap;
    end

    always_comb begin
        n_state   = r_state;
        n_tap     = r_tap;
        w_rd_en   = 1'b0;
        w_load    = 1'b0;
        w_ctl.clear = 1'b0;
        // Read data arrives in the cycle after the read; its gain follows with it.
        w_ctl.en    = r_rd_v;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctl.clear = 1'b1;
                    n_tap       = '0;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                // One memory read per tap, one tap per cycle.
                w_rd_en = 1'b1;
                n_tap   = r_tap + TAP_W'(1);
                if (r_tap == TAP_W'(TAP_COUNT - 1)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!r_rd_v && !w_sts.busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the finished sum until the output register is free.
                if (!r_out_valid || !i_stall) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    mtdr_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_accept),
        .i_wr_data  (i_sample_in),
        .i_rd_en    (w_rd_en),
        .i_rd_delay (r_delay[r_tap]),
        .o_rd_data  (w_rd_data)
    );

    mtdr_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_gain   (r_gain[r_tap_d]),
        .i_sample (w_rd_data),
        .o_sts    (w_sts)
    );

    // Output register parts the result side from the sample side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_sts.result;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_echo_out = r_out;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("input taken while a sample is in progress");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!r_rd_v && !w_sts.busy))
        else $error("sum finished with terms still in flight");

endmodule
